// File: design/r2pc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2pc_pkg - shared types and constants for the roots-to-coefficients core
// Request and response payload structs and fixed-point constants.
// ----------------------------------------------------------------------------
package r2pc_pkg;

   // Q8.8 root / scale width and Q48.16 coefficient width
   localparam int ROOT_W = 16;
   localparam int COEF_W = 64;
   localparam int IDX_W  = 5;

   // 1.0 in the coefficient format (16 fraction bits)
   localparam logic signed [COEF_W-1:0] ONE_Q16   = 64'sd65536;
   localparam logic [COEF_W-1:0]        SIGN_MASK = 64'h8000_0000_0000_0000;
   localparam logic signed [COEF_W-1:0] COEF_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [COEF_W-1:0] COEF_MIN  = 64'sh8000_0000_0000_0000;

   // reset value of the leading coefficient register (1.0 in Q8.8)
   localparam logic signed [ROOT_W-1:0] LEAD_RESET = 16'sd256;

   typedef struct packed {
      logic signed [ROOT_W-1:0] root_value;
      logic                     last_root;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         coef_index;
      logic signed [COEF_W-1:0] coef_value;
      logic                     overflow;
      logic                     last_coef;
   } rsp_type;

endpackage

// File: design/r2pc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2pc_ram - generic single-port RAM
// One address per cycle, write or read, registered read data.
// ----------------------------------------------------------------------------
module r2pc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 17
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                          wdata,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/roots_to_poly_coefficients_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roots_to_poly_coefficients_core - polynomial coefficients from roots
// Multiplies the kept polynomial by (x - root) for each root that fits and, on the
// last root, streams out all coefficients scaled by the leading coefficient.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                payload
//  -------  ---------  -----------------------  ------------------------------
//  req_     in         start & !busy            root_value Q8.8, last_root
//  rsp_     out        rsp_valid, 1-cycle pulse coef_index, coef_value, flags
//  csr_     in         csr_valid & csr_ready    leading_coefficient Q8.8
//
//  Each coefficient passes the shared 32x17 multiplier in six steps (read,
//  magnitude, low, high, round, add/sat). A root with c roots held updates c+2
//  entries from the new top down; a last root adds a scaling pass and an output
//  pass (read, response) over n+1 entries, n being the final root count. A root
//  dropped on a full store raises busy only with a last mark, for those two
//  passes. Synchronous reset, no clearing pass; responses cannot be stalled.
// ----------------------------------------------------------------------------
module roots_to_poly_coefficients_core
   import r2pc_pkg::*;
#(
   parameter int MAX_ROOTS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   // request
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   // response
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   // configuration
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic signed [ROOT_W-1:0] csr_data
);

   localparam int DEPTH = MAX_ROOTS + 1;
   localparam int CW    = $clog2(MAX_ROOTS + 1);
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RM_W  = ROOT_W + 1;              // |r| up to 2^15
   localparam int PP_W  = 32 + RM_W;                // partial product
   localparam int SUM_W = 64 + RM_W;                // full product + guard

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,    // present RAM address
      ST_ABS,   // operands in, take magnitude of x
      ST_MLO,   // low half product
      ST_MHI,   // high half product
      ST_RND,   // join halves, round, range check
      ST_ACC,   // a -/+ m, saturate, write back
      ST_EOUT   // response from RAM data
   } state_type;

   state_type                state_ff, state_in;
   logic                     scale_ff, scale_in;    // scaling pass, not update
   logic                     emit_ff, emit_in;      // output pass
   logic [CW-1:0]            k_ff, k_in;
   logic [CW-1:0]            count_ff, count_in;
   logic                     ovf_ff, ovf_in;
   logic                     last_ff, last_in;
   logic signed [ROOT_W-1:0] lead_ff, lead_in;
   logic                     rneg_ff, rneg_in;
   logic [RM_W-1:0]          rm_ff, rm_in;
   logic signed [COEF_W-1:0] x_ff, x_in;
   logic signed [COEF_W-1:0] a_ff, a_in;
   logic [COEF_W-1:0]        xm_ff, xm_in;
   logic                     neg_ff, neg_in;
   logic [PP_W-1:0]          lo_ff, lo_in;
   logic [PP_W-1:0]          hi_ff, hi_in;
   logic [COEF_W-1:0]        m_ff, m_in;
   logic                     big_ff, big_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   // store
   logic                     ram_we;
   logic [AW-1:0]            ram_addr;
   logic [COEF_W-1:0]        ram_wdata;
   logic [COEF_W-1:0]        ram_rdata;

   // datapath
   logic signed [COEF_W-1:0] x_op;
   logic signed [RM_W-1:0]   r_root;
   logic signed [RM_W-1:0]   r_lead;
   logic [31:0]              mul_a;
   logic [PP_W-1:0]          mul_p;
   logic [SUM_W-1:0]         prod_sum;
   logic [COEF_W-1:0]        ua;
   logic [COEF_W:0]          diff;
   logic [COEF_W:0]          addv;
   logic signed [COEF_W-1:0] acc_res;
   logic                     acc_sat;

   r2pc_ram #(
      .WIDTH (COEF_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // root and scale factor as 17-bit signed multipliers; scaling uses -lead
   assign r_root = RM_W'(req_data.root_value);
   assign r_lead = -RM_W'(lead_ff);

   // shared multiplier: low then high 32 bits of |x|
   assign mul_a = (state_ff == ST_MLO) ? xm_ff[31:0] : xm_ff[63:32];
   assign mul_p = PP_W'(mul_a) * PP_W'(rm_ff);

   assign prod_sum = {hi_ff, 32'b0} + SUM_W'(lo_ff) + SUM_W'(128);

   // x: in the update pass it is carried over from the previous step
   assign x_op = scale_ff ? signed'(ram_rdata) : x_ff;

   // a - m (or a + m when the product is negative) in offset-binary
   assign ua   = a_ff ^ SIGN_MASK;
   assign diff = {1'b0, ua} - {1'b0, m_ff};
   assign addv = {1'b0, ua} + {1'b0, m_ff};

   always_comb begin
      acc_sat = 1'b0;
      acc_res = '0;
      if (big_ff) begin
         acc_sat = 1'b1;
         acc_res = neg_ff ? COEF_MAX : COEF_MIN;
      end else if (!neg_ff) begin
         if (diff[COEF_W]) begin
            acc_sat = 1'b1;
            acc_res = COEF_MIN;
         end else begin
            acc_res = signed'(diff[COEF_W-1:0] ^ SIGN_MASK);
         end
      end else begin
         if (addv[COEF_W]) begin
            acc_sat = 1'b1;
            acc_res = COEF_MAX;
         end else begin
            acc_res = signed'(addv[COEF_W-1:0] ^ SIGN_MASK);
         end
      end
   end

   // RAM port: write in the add step, otherwise address for the next read
   always_comb begin
      ram_we    = (state_ff == ST_ACC);
      ram_wdata = acc_res;
      if (!scale_ff && !emit_ff && state_ff == ST_RD) begin
         ram_addr = AW'(k_ff - CW'(1));     // old[k-1]
      end else begin
         ram_addr = AW'(k_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      scale_in     = scale_ff;
      emit_in      = emit_ff;
      k_in         = k_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      lead_in      = lead_ff;
      rneg_in      = rneg_ff;
      rm_in        = rm_ff;
      x_in         = x_ff;
      a_in         = a_ff;
      xm_in        = xm_ff;
      neg_in       = neg_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      m_in         = m_ff;
      big_in       = big_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               lead_in = csr_data;
            end
            if (start) begin
               last_in = req_data.last_root;
               if (count_ff >= CW'(MAX_ROOTS)) begin
                  // store full: drop the root, still finish on a last mark
                  ovf_in = 1'b1;
                  if (req_data.last_root) begin
                     scale_in = 1'b1;
                     emit_in  = 1'b0;
                     k_in     = '0;
                     rneg_in  = r_lead[RM_W-1];
                     rm_in    = r_lead[RM_W-1] ? RM_W'(-r_lead) : RM_W'(r_lead);
                     state_in = ST_RD;
                  end
               end else begin
                  // update runs from the new top entry down to zero
                  scale_in = 1'b0;
                  emit_in  = 1'b0;
                  k_in     = count_ff + CW'(1);
                  x_in     = '0;
                  rneg_in  = r_root[RM_W-1];
                  rm_in    = r_root[RM_W-1] ? RM_W'(-r_root) : RM_W'(r_root);
                  state_in = ST_RD;
               end
            end
         end

         ST_RD: begin
            state_in = emit_ff ? ST_EOUT : ST_ABS;
         end

         ST_ABS: begin
            if (scale_ff || k_ff == '0) begin
               a_in = '0;
            end else if (count_ff == '0) begin
               a_in = ONE_Q16;                      // empty store reads as 1.0
            end else begin
               a_in = signed'(ram_rdata);
            end
            x_in     = x_op;
            xm_in    = x_op[COEF_W-1] ? COEF_W'(-x_op) : COEF_W'(x_op);
            neg_in   = x_op[COEF_W-1] ^ rneg_ff;
            state_in = ST_MLO;
         end

         ST_MLO: begin
            lo_in    = mul_p;
            state_in = ST_MHI;
         end

         ST_MHI: begin
            hi_in    = mul_p;
            state_in = ST_RND;
         end

         ST_RND: begin
            big_in   = |prod_sum[SUM_W-1:72];
            m_in     = prod_sum[71:8];
            state_in = ST_ACC;
         end

         ST_ACC: begin
            if (acc_sat) begin
               ovf_in = 1'b1;
            end
            if (!scale_ff) begin
               x_in = a_ff;                         // old[k-1] is next x
               if (k_ff == '0) begin
                  count_in = count_ff + CW'(1);
                  if (last_ff) begin
                     scale_in = 1'b1;
                     k_in     = '0;
                     rneg_in  = r_lead[RM_W-1];
                     rm_in    = r_lead[RM_W-1] ? RM_W'(-r_lead) : RM_W'(r_lead);
                     state_in = ST_RD;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  k_in     = k_ff - CW'(1);
                  state_in = ST_RD;
               end
            end else begin
               if (k_ff == count_ff) begin
                  // all scaled: overflow flag is final, start output
                  scale_in = 1'b0;
                  emit_in  = 1'b1;
                  k_in     = '0;
               end else begin
                  k_in = k_ff + CW'(1);
               end
               state_in = ST_RD;
            end
         end

         ST_EOUT: begin
            rsp_valid_in       = 1'b1;
            rsp_in.coef_index  = IDX_W'(k_ff);
            rsp_in.coef_value  = signed'(ram_rdata);
            rsp_in.overflow    = ovf_ff;
            rsp_in.last_coef   = (k_ff == count_ff);
            if (k_ff == count_ff) begin
               // run done: back to the constant polynomial 1
               emit_in  = 1'b0;
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end else begin
               k_in     = k_ff + CW'(1);
               state_in = ST_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scale_ff     <= 1'b0;
         emit_ff      <= 1'b0;
         k_ff         <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         lead_ff      <= LEAD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scale_ff     <= scale_in;
         emit_ff      <= emit_in;
         k_ff         <= k_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         lead_ff      <= lead_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rneg_ff <= rneg_in;
      rm_ff   <= rm_in;
      x_ff    <= x_in;
      a_ff    <= a_in;
      xm_ff   <= xm_in;
      neg_ff  <= neg_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      m_ff    <= m_in;
      big_ff  <= big_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - roots_to_poly_coefficients_core self-checking bench
// Feeds roots as requests and tracks the expanded polynomial bit for bit. Every
// streamed coefficient is checked in order. Runs with several leading
// coefficients and with varied gaps between requests.
// ----------------------------------------------------------------------------
module testbench
   import r2pc_pkg::*;
();

   localparam int ROOT_CAP    = 16;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 300;     // longest single request is well under this
   localparam int MAX_REPORTS = 10;
   localparam int PHASE_ROOTS = 92;

   localparam logic signed [ROOT_W-1:0] ROOT_MAX = 16'sh7FFF;
   localparam logic signed [ROOT_W-1:0] ROOT_MIN = 16'sh8000;
   localparam logic signed [ROOT_W-1:0] ROOT_ONE = 16'sd256;

   // -------------------------------------------------------------------------
   // Polynomial tracker: keeps its own coefficient array, root count, sticky
   // overflow and leading coefficient, and queues the coefficients due.
   // -------------------------------------------------------------------------
   class vieta_tracker;
      logic signed [COEF_W-1:0] coefs [0:ROOT_CAP];
      int unsigned              held;
      bit                       ovf_run;
      bit                       sat_hit;
      logic signed [ROOT_W-1:0] lead;
      rsp_type                  coef_due [$];
      int unsigned              faults;
      int unsigned              roots_seen;
      int unsigned              polys_done;
      int unsigned              coefs_checked;

      function new();
         lead          = LEAD_RESET;
         faults        = 0;
         roots_seen    = 0;
         polys_done    = 0;
         coefs_checked = 0;
         clear();
      endfunction

      // back to the constant polynomial 1.0
      function void clear();
         for (int k = 0; k <= ROOT_CAP; k++) coefs[k] = '0;
         coefs[0] = ONE_Q16;
         held     = 0;
         ovf_run  = 1'b0;
      endfunction

      // acc - x*r/256, rounded half away from zero, saturated to 64 bits
      function logic signed [COEF_W-1:0] mul_sub_round(input logic signed [COEF_W-1:0] acc,
                                                       input logic signed [COEF_W-1:0] x,
                                                       input logic signed [31:0] r);
         logic [COEF_W-1:0]  x_mag;
         logic [31:0]        r_mag;
         logic [95:0]        prod;
         logic signed [97:0] total;
         bit                 neg;
         neg   = x[COEF_W-1] ^ r[31];
         x_mag = x[COEF_W-1] ? -x : x;
         r_mag = r[31] ? -r : r;
         prod  = ({32'd0, x_mag} * {64'd0, r_mag} + 96'd128) >> 8;
         // scaled product alone out of range
         if (prod[95:64] != '0) begin
            sat_hit = 1'b1;
            return neg ? COEF_MAX : COEF_MIN;
         end
         total = acc;
         if (neg) begin
            total = total + $signed({34'd0, prod[63:0]});
         end else begin
            total = total - $signed({34'd0, prod[63:0]});
         end
         if (total > COEF_MAX) begin
            sat_hit = 1'b1;
            return COEF_MAX;
         end
         if (total < COEF_MIN) begin
            sat_hit = 1'b1;
            return COEF_MIN;
         end
         return total[COEF_W-1:0];
      endfunction

      // accepted root request: multiply by (x - r), emit on the last root
      function void note_root(req_type rq);
         logic signed [31:0]       r;
         logic signed [31:0]       neg_lead;
         logic signed [COEF_W-1:0] scaled [0:ROOT_CAP];
         rsp_type                  due;
         r = {{16{rq.root_value[ROOT_W-1]}}, rq.root_value};
         roots_seen++;
         if (held >= ROOT_CAP) begin
            // store full: root dropped, run flagged
            ovf_run = 1'b1;
         end else begin
            sat_hit = 1'b0;
            coefs[held+1] = coefs[held];
            for (int k = held; k > 0; k--) coefs[k] = mul_sub_round(coefs[k-1], coefs[k], r);
            coefs[0] = mul_sub_round('0, coefs[0], r);
            held++;
            if (sat_hit) ovf_run = 1'b1;
         end
         if (!rq.last_root) return;
         neg_lead = -{{16{lead[ROOT_W-1]}}, lead};
         sat_hit  = 1'b0;
         for (int k = 0; k <= held; k++) scaled[k] = mul_sub_round('0, coefs[k], neg_lead);
         if (sat_hit) ovf_run = 1'b1;
         for (int k = 0; k <= held; k++) begin
            due.coef_index = IDX_W'(k);
            due.coef_value = scaled[k];
            due.overflow   = ovf_run;
            due.last_coef  = (k == held);
            coef_due = {coef_due, due};
         end
         polys_done++;
         clear();
      endfunction

      // one streamed coefficient against the oldest one due
      function void check_coef(rsp_type got);
         rsp_type want;
         coefs_checked++;
         if (coef_due.size() == 0) begin
            faults++;
            if (faults <= MAX_REPORTS)
               $display("%0t: unexpected coefficient idx %0d val %0d ovf %0b last %0b",
                        $time, got.coef_index, got.coef_value, got.overflow, got.last_coef);
            return;
         end
         want = coef_due.pop_front();
         if (got.coef_index !== want.coef_index || got.coef_value !== want.coef_value ||
             got.overflow !== want.overflow || got.last_coef !== want.last_coef) begin
            faults++;
            if (faults <= MAX_REPORTS) begin
               $display("%0t: coefficient mismatch", $time);
               $display("   expected idx %0d val %0d ovf %0b last %0b",
                        want.coef_index, want.coef_value, want.overflow, want.last_coef);
               $display("   actual   idx %0d val %0d ovf %0b last %0b",
                        got.coef_index, got.coef_value, got.overflow, got.last_coef);
            end
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals, clock, DUT
   // -------------------------------------------------------------------------
   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   req_type                  req_data;
   logic                     rsp_valid;
   rsp_type                  rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic signed [ROOT_W-1:0] csr_data;

   vieta_tracker tracker;
   int unsigned  idle_pct;
   int unsigned  cycle_count;

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   roots_to_poly_coefficients_core #(
      .MAX_ROOTS (ROOT_CAP)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Responses cannot be stalled: each strobe is one coefficient, taken at the
   // edge that closes its cycle. Sampled values are pre-edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid) tracker.check_coef(rsp_data);
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Raise start with the root and hold it until a request is taken (start
   // high, busy low at an edge). start stays high on return so back-to-back
   // requests never lower and raise it in the same step.
   task automatic send_root(input logic signed [ROOT_W-1:0] value, input logic is_last);
      req_type rq;
      rq.root_value = value;
      rq.last_root  = is_last;
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      tracker.note_root(rq);
   endtask

   // random sender gap ahead of the next request
   task automatic request_gap();
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   // hold off until every coefficient due has been seen
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (tracker.coef_due.size() != 0);
   endtask

   // Leading coefficient write, only with the core idle. A trailing non-final
   // root gives no coefficients, so allow it time to finish after the drain.
   task automatic write_lead(input logic signed [ROOT_W-1:0] value);
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.lead = value;
   endtask

   // mostly modest roots so that runs stay in range, some full-range noise
   function automatic logic signed [ROOT_W-1:0] pick_root();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 70) return ROOT_W'(int'($urandom_range(2047)) - 1024);
      if (sel < 90) return ROOT_W'($urandom());
      case ($urandom_range(2))
         0: return '0;
         1: return ROOT_MAX;
         default: return ROOT_MIN;
      endcase
   endfunction

   task automatic run_directed();
      idle_pct = 0;
      // single roots at zero and at the most negative value
      send_root('0, 1'b1);
      send_root(ROOT_MIN, 1'b1);
      // (x + 128)^7: constant term runs past the 64-bit range on the seventh root
      for (int i = 1; i <= 7; i++) send_root(ROOT_MIN, i == 7);
      // one root too many: the extra root is dropped yet still closes the run
      for (int i = 1; i <= ROOT_CAP + 1; i++) send_root(ROOT_ONE, i == ROOT_CAP + 1);
   endtask

   // well-formed polynomials of random degree, some longer than the store
   task automatic run_random_phase(input int unsigned pct);
      int unsigned sent;
      int unsigned len;
      int unsigned pick;
      sent     = 0;
      idle_pct = pct;
      while (sent < PHASE_ROOTS) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            len = $urandom_range(6, 1);
         end else if (pick < 90) begin
            len = $urandom_range(ROOT_CAP, 7);
         end else begin
            len = $urandom_range(ROOT_CAP + 4, ROOT_CAP + 1);
         end
         for (int i = 1; i <= len; i++) begin
            request_gap();
            send_root(pick_root(), i == len);
            sent++;
         end
         if ($urandom_range(19) == 0) wait_drained();
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      idle_pct  = 0;
      tracker   = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      // at least one full drain with the sender held off
      wait_drained();
      write_lead(ROOT_MIN);
      run_random_phase(34);
      write_lead(ROOT_MAX);
      run_random_phase(69);
      write_lead(ROOT_W'($urandom()));
      run_random_phase(0);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (tracker.coef_due.size() != 0) begin
         $display("%0d coefficients never arrived", tracker.coef_due.size());
         tracker.faults += tracker.coef_due.size();
      end

      $display("Run: %0d roots in %0d polynomials, %0d coefficients checked, %0d faults,",
               tracker.roots_seen, tracker.polys_done, tracker.coefs_checked, tracker.faults);
      $display("     leading coefficient at reset value, both extremes and random; %0d cycles",
               cycle_count);
      if (tracker.faults == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: filelist.f
design/r2pc_pkg.sv
design/r2pc_ram.sv
design/roots_to_poly_coefficients_core.sv
tb/sv/testbench.sv
